// ----- src/slcf_pkg.sv -----
// Shared constants, types and tables of the scan-line curvature filter.
`timescale 1ns / 1ps
package slcf_pkg;

  localparam int SPAN_DEF        = 5;
  localparam int COORD_BITS_DEF  = 24;
  localparam int CORDIC_STEPS    = 15;
  localparam int ROOT_STEPS      = 32;
  localparam int DIV_STEPS       = 32;
  localparam int STEP_W          = 6;
  localparam int IDX_W           = 5;
  localparam int ANG_W           = 18;
  localparam int HALF_TURN       = 32768;
  localparam int FULL_TURN       = 65536;
  localparam int AZ_LIMIT_W      = 15;
  localparam int DEPTH_LIMIT_W   = 23;
  localparam int SMOOTH_W        = 32;
  localparam int ROOT_W          = 32;
  localparam int AZ_LIMIT_RST    = 382;
  localparam int DEPTH_LIMIT_RST = 819;
  localparam longint BIG_DIFF    = 64'sd1073741824;

  // Register index, taken from address bit 2.
  localparam logic REG_AZ_LIMIT    = 1'b0;
  localparam logic REG_DEPTH_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    MS_CTR,
    MS_D,
    MS_LIM,
    MS_GAP
  } mul_sel_t;

  typedef struct packed {
    logic             load;
    logic             sum_step;
    logic             cordic_init;
    logic             cordic_step;
    logic [3:0]       cstep;
    logic             mul_issue;
    logic             mul_acc;
    logic             prv_load;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             div_init;
    logic             div_step;
    logic             out_load;
    mul_sel_t         sel;
    logic [1:0]       axis;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic eval_on_load;
    logic out_full;
  } dp_status_t;

  // Rounded atan(2^-k) in 1/65536 turn.
  function automatic logic [13:0] atan_turn(input logic [3:0] k);
    logic [13:0] v;
    unique case (k)
      4'd0:    v = 14'd8192;
      4'd1:    v = 14'd4836;
      4'd2:    v = 14'd2555;
      4'd3:    v = 14'd1297;
      4'd4:    v = 14'd651;
      4'd5:    v = 14'd326;
      4'd6:    v = 14'd163;
      4'd7:    v = 14'd81;
      4'd8:    v = 14'd41;
      4'd9:    v = 14'd20;
      4'd10:   v = 14'd10;
      4'd11:   v = 14'd5;
      4'd12:   v = 14'd3;
      4'd13:   v = 14'd1;
      4'd14:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/slcf_ctrl.sv -----
// Sequencing state machine of the scan-line curvature filter.
`timescale 1ns / 1ps
module slcf_ctrl #(
  parameter int SPAN = slcf_pkg::SPAN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  slcf_pkg::dp_status_t status,
  output slcf_pkg::dp_cmd_t    cmd
);
  import slcf_pkg::*;

  localparam int NPTS = 2 * SPAN + 1;
  localparam int PH1  = (NPTS > CORDIC_STEPS + 1) ? NPTS : CORDIC_STEPS + 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_ACC  = 7'b0001000,
    S_SQRT = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  mul_sel_t         sel_r, sel_nxt;
  logic [1:0]       axis_r, axis_nxt;
  logic [IDX_W-1:0] pair_r, pair_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    axis_nxt  = axis_r;
    pair_nxt  = pair_r;
    cmd       = '0;
    cmd.sel   = sel_r;
    cmd.axis  = axis_r;
    cmd.idx   = (sel_r == MS_GAP) ? IDX_W'(pair_r + 1'b1) : '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid && status.eval_on_load) begin
          state_nxt = S_SCAN;
          cnt_nxt   = '0;
        end
      end
      S_SCAN: begin
        cmd.idx         = cnt_r[IDX_W-1:0];
        cmd.sum_step    = (cnt_r < STEP_W'(NPTS));
        cmd.cordic_init = (cnt_r == '0);
        cmd.cordic_step = (cnt_r != '0) && (cnt_r <= STEP_W'(CORDIC_STEPS));
        cmd.cstep       = 4'(cnt_r - 1'b1);
        cnt_nxt         = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(PH1 - 1)) begin
          state_nxt = S_MUL;
          sel_nxt   = MS_CTR;
          axis_nxt  = '0;
          pair_nxt  = '0;
        end
      end
      S_MUL: begin
        cmd.mul_issue = 1'b1;
        cmd.prv_load  = (sel_r == MS_LIM);
        state_nxt     = S_ACC;
      end
      S_ACC: begin
        cmd.mul_acc  = 1'b1;
        cmd.prv_load = (sel_r == MS_GAP) && (axis_r == 2'd2);
        state_nxt    = S_MUL;
        if (sel_r == MS_LIM) begin
          sel_nxt  = MS_GAP;
          axis_nxt = '0;
          pair_nxt = '0;
        end else if (axis_r != 2'd2) begin
          axis_nxt = axis_r + 1'b1;
        end else begin
          axis_nxt = '0;
          unique case (sel_r)
            MS_CTR: sel_nxt = MS_D;
            MS_D: begin
              cmd.sqrt_init = 1'b1;
              cnt_nxt       = '0;
              state_nxt     = S_SQRT;
            end
            MS_GAP: begin
              if (pair_r == IDX_W'(NPTS - 1)) begin
                cmd.div_init = 1'b1;
                cnt_nxt      = '0;
                state_nxt    = S_DIV;
              end else begin
                pair_nxt = pair_r + 1'b1;
              end
            end
            default: state_nxt = S_MUL;
          endcase
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(ROOT_STEPS - 1)) begin
          state_nxt = S_MUL;
          sel_nxt   = MS_LIM;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(DIV_STEPS - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!status.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      sel_r   <= MS_CTR;
      axis_r  <= '0;
      pair_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
      axis_r  <= axis_nxt;
      pair_r  <= pair_nxt;
    end
  end

endmodule

// ----- src/slcf_datapath.sv -----
// Point window, shared multiplier, CORDIC lanes, root and divide units.
`timescale 1ns / 1ps
module slcf_datapath #(
  parameter int SPAN       = slcf_pkg::SPAN_DEF,
  parameter int COORD_BITS = slcf_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic signed [COORD_BITS-1:0]           in_pos_x,
  input  logic signed [COORD_BITS-1:0]           in_pos_y,
  input  logic signed [COORD_BITS-1:0]           in_pos_z,
  input  logic                                   in_line_end,
  input  logic [slcf_pkg::AZ_LIMIT_W-1:0]        az_limit,
  input  logic [slcf_pkg::DEPTH_LIMIT_W-1:0]     depth_limit,
  input  slcf_pkg::dp_cmd_t                      cmd,
  output slcf_pkg::dp_status_t                   status,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [COORD_BITS-1:0]           out_x,
  output logic signed [COORD_BITS-1:0]           out_y,
  output logic signed [COORD_BITS-1:0]           out_z,
  output logic [slcf_pkg::SMOOTH_W-1:0]          out_smoothness
);
  import slcf_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int WIN  = 2 * SPAN + 2;
  localparam int IW   = $clog2(WIN);
  localparam int CNTW = $clog2(WIN + 2);
  localparam int DW   = CB + 5;
  localparam int MW   = (CB + 2 > 34) ? CB + 2 : 34;
  localparam int PW   = 2 * MW;
  localparam int GW   = PW + 2;
  localparam int CW   = CB + 3;

  logic signed [CB-1:0]    win_r [WIN][3];
  logic [CNTW-1:0]         lcnt_r, lcnt_inc;
  logic signed [DW-1:0]    d_r [3];
  logic signed [CW-1:0]    cx_r [2];
  logic signed [CW-1:0]    cy_r [2];
  logic signed [ANG_W-1:0] cz_r [2];
  logic signed [PW-1:0]    prod_r;
  logic [63:0]             n_r, s_r;
  logic [PW-1:0]           lim_r;
  logic signed [GW-1:0]    gacc_r, gacc_nxt;
  logic [GW-1:0]           gmag;
  logic                    depth_ok_r;
  logic signed [CB-1:0]    prv_r [3];
  logic [63:0]             sq_rem_r, sq_res_r, sq_bit_r, sq_t;
  logic [32:0]             drem_r;
  logic [31:0]             dq_r;
  logic                    sat_r;
  logic [33:0]             dv_t;
  logic                    dv_ge;
  logic                    out_valid_r;
  logic signed [CB-1:0]    ox_r, oy_r, oz_r;
  logic [SMOOTH_W-1:0]     osm_r;

  logic signed [CB-1:0]    rd [3];
  logic signed [CB-1:0]    ctr_ax, rd_ax, prv_ax;
  logic signed [DW-1:0]    d_ax;
  logic signed [CB:0]      gap;
  logic signed [MW-1:0]    op_a, op_b;
  logic [ROOT_W-1:0]       root;
  logic                    big;
  logic signed [ANG_W-1:0] zw [2];
  logic signed [ANG_W-1:0] az;
  logic [ANG_W-1:0]        azmag;
  logic                    az_ok;
  logic signed [ANG_W-1:0] ang;
  logic [3:0]              sh;

  assign rd   = win_r[cmd.idx[IW-1:0]];
  assign root = sq_res_r[ROOT_W-1:0];
  assign sh   = cmd.cstep;
  assign ang  = $signed(ANG_W'(atan_turn(cmd.cstep)));

  assign lcnt_inc = (lcnt_r < CNTW'(WIN + 1)) ? CNTW'(lcnt_r + 1'b1) : lcnt_r;
  assign status.eval_on_load = (lcnt_inc == CNTW'(WIN + 1));
  assign status.out_full     = out_valid_r;

  always_comb begin
    ctr_ax = win_r[SPAN][0];
    rd_ax  = rd[0];
    prv_ax = prv_r[0];
    d_ax   = d_r[0];
    unique case (cmd.axis)
      2'd1: begin
        ctr_ax = win_r[SPAN][1];
        rd_ax  = rd[1];
        prv_ax = prv_r[1];
        d_ax   = d_r[1];
      end
      2'd2: begin
        ctr_ax = win_r[SPAN][2];
        rd_ax  = rd[2];
        prv_ax = prv_r[2];
        d_ax   = d_r[2];
      end
      default: ;
    endcase
  end

  assign gap = (CB+1)'(prv_ax) - (CB+1)'(rd_ax);

  always_comb begin
    op_a = MW'(ctr_ax);
    op_b = MW'(ctr_ax);
    unique case (cmd.sel)
      MS_CTR: ;
      MS_D: begin
        op_a = MW'(d_ax);
        op_b = MW'(d_ax);
      end
      MS_LIM: begin
        op_a = MW'($signed({1'b0, depth_limit}));
        op_b = MW'($signed({1'b0, root}));
      end
      MS_GAP: begin
        op_a = MW'(gap);
        op_b = MW'(ctr_ax);
      end
      default: ;
    endcase
  end

  always_comb begin
    big = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (longint'(d_r[a]) >= BIG_DIFF || longint'(d_r[a]) <= -BIG_DIFF) big = 1'b1;
    end
  end

  assign gacc_nxt = ((cmd.axis == 2'd0) ? GW'(0) : gacc_r) + GW'(prod_r);
  assign gmag     = gacc_nxt[GW-1] ? GW'(-gacc_nxt) : GW'(gacc_nxt);

  assign sq_t  = sq_res_r + sq_bit_r;
  assign dv_t  = {drem_r, dq_r[31]};
  assign dv_ge = (dv_t >= {2'b00, root});

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      zw[l] = (cz_r[l] >= ANG_W'(HALF_TURN)) ? ANG_W'(cz_r[l] - ANG_W'(FULL_TURN)) : cz_r[l];
    end
  end
  assign az    = zw[0] - zw[1];
  assign azmag = az[ANG_W-1] ? ANG_W'(-az) : ANG_W'(az);
  assign az_ok = (azmag < ANG_W'(az_limit));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < WIN - 1; k++) win_r[k] <= win_r[k+1];
      win_r[WIN-1][0] <= in_pos_x;
      win_r[WIN-1][1] <= in_pos_y;
      win_r[WIN-1][2] <= in_pos_z;
      for (int a = 0; a < 3; a++) d_r[a] <= '0;
      n_r        <= '0;
      s_r        <= '0;
      depth_ok_r <= 1'b1;
    end
    if (cmd.sum_step) begin
      for (int a = 0; a < 3; a++) begin
        if (cmd.idx == IDX_W'(SPAN))
          d_r[a] <= d_r[a] - DW'(2 * SPAN) * DW'(win_r[SPAN][a]);
        else
          d_r[a] <= d_r[a] + DW'(rd[a]);
      end
    end
    if (cmd.cordic_init) begin
      for (int l = 0; l < 2; l++) begin
        if (win_r[l == 0 ? 2 * SPAN : 0][0] < 0) begin
          cx_r[l] <= -CW'(win_r[l == 0 ? 2 * SPAN : 0][0]);
          cy_r[l] <= -CW'(win_r[l == 0 ? 2 * SPAN : 0][1]);
          cz_r[l] <= ANG_W'(HALF_TURN);
        end else begin
          cx_r[l] <= CW'(win_r[l == 0 ? 2 * SPAN : 0][0]);
          cy_r[l] <= CW'(win_r[l == 0 ? 2 * SPAN : 0][1]);
          cz_r[l] <= '0;
        end
      end
    end
    if (cmd.cordic_step) begin
      for (int l = 0; l < 2; l++) begin
        if (cy_r[l] > 0) begin
          cx_r[l] <= cx_r[l] + (cy_r[l] >>> sh);
          cy_r[l] <= cy_r[l] - (cx_r[l] >>> sh);
          cz_r[l] <= cz_r[l] + ang;
        end else if (cy_r[l] < 0) begin
          cx_r[l] <= cx_r[l] - (cy_r[l] >>> sh);
          cy_r[l] <= cy_r[l] + (cx_r[l] >>> sh);
          cz_r[l] <= cz_r[l] - ang;
        end
      end
    end
    if (cmd.mul_issue) prod_r <= op_a * op_b;
    if (cmd.prv_load) begin
      for (int a = 0; a < 3; a++) prv_r[a] <= rd[a];
    end
    if (cmd.mul_acc) begin
      unique case (cmd.sel)
        MS_CTR: n_r <= n_r + prod_r[63:0];
        MS_D:   s_r <= s_r + prod_r[63:0];
        MS_LIM: lim_r <= PW'(prod_r);
        MS_GAP: begin
          gacc_r <= gacc_nxt;
          if (cmd.axis == 2'd2 && gmag > GW'(lim_r)) depth_ok_r <= 1'b0;
        end
        default: ;
      endcase
    end
    if (cmd.sqrt_init) begin
      sq_rem_r <= n_r;
      sq_res_r <= '0;
      sq_bit_r <= 64'd1 << 62;
    end
    if (cmd.sqrt_step) begin
      if (sq_rem_r >= sq_t) begin
        sq_rem_r <= sq_rem_r - sq_t;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
    if (cmd.div_init) begin
      sat_r  <= big || (root == '0) || (s_r >= {4'b0000, root, 28'd0});
      drem_r <= s_r[60:28];
      dq_r   <= {s_r[27:0], 4'b0000};
    end
    if (cmd.div_step) begin
      drem_r <= dv_ge ? 33'(dv_t - {2'b00, root}) : dv_t[32:0];
      dq_r   <= {dq_r[30:0], dv_ge};
    end
    if (cmd.out_load) begin
      ox_r  <= win_r[SPAN][0];
      oy_r  <= win_r[SPAN][1];
      oz_r  <= win_r[SPAN][2];
      osm_r <= sat_r ? '1 : dq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) lcnt_r <= in_line_end ? '0 : lcnt_inc;
      if (cmd.out_load && az_ok && depth_ok_r) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x          = ox_r;
  assign out_y          = oy_r;
  assign out_z          = oz_r;
  assign out_smoothness = osm_r;

endmodule

// ----- src/scan_line_curvature_filter_core.sv -----
// Top level of the scan-line curvature filter: configuration registers and core.
`timescale 1ns / 1ps
// The block takes the points of one scan line in order, keeps the newest
// 2*SPAN+2 of them and, once a line holds enough points, judges the center
// point: its smoothness (squared norm of the neighbour sum minus 2*SPAN times
// the center, over the range, unsigned Q28.4, saturating) and two continuity
// tests (azimuth spread of the outer neighbours and projected gaps of all
// adjacent pairs). A passing center is offered as one result transfer. A point
// that completes no center leaves the block idle and ready for the next point. A
// point that completes a center holds the input through the scan (neighbour
// sums and the two CORDIC lanes), the passes on the one shared multiplier,
// the bit-serial root and the bit-serial divider, and the hand-over of the
// result, which waits while an earlier result is still pending. The output
// register lets the next point transfer while a result still waits.
// Registers: azimuth limit at address 0, depth gap limit at address 4.
module scan_line_curvature_filter_core #(
  parameter int SPAN       = slcf_pkg::SPAN_DEF,
  parameter int COORD_BITS = slcf_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS-1:0]  in_pos_x,
  input  logic signed [COORD_BITS-1:0]  in_pos_y,
  input  logic signed [COORD_BITS-1:0]  in_pos_z,
  input  logic                          in_line_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_BITS-1:0]  out_x,
  output logic signed [COORD_BITS-1:0]  out_y,
  output logic signed [COORD_BITS-1:0]  out_z,
  output logic [slcf_pkg::SMOOTH_W-1:0] out_smoothness,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import slcf_pkg::*;

  logic [AZ_LIMIT_W-1:0]    az_limit_r;
  logic [DEPTH_LIMIT_W-1:0] depth_limit_r;
  logic                     wr_en;
  dp_cmd_t                  cmd;
  dp_status_t               status;

  // The register is written in the access phase of an APB write.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_DEPTH_LIMIT) ? 32'(depth_limit_r) : 32'(az_limit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      az_limit_r    <= AZ_LIMIT_W'(AZ_LIMIT_RST);
      depth_limit_r <= DEPTH_LIMIT_W'(DEPTH_LIMIT_RST);
    end else if (wr_en) begin
      if (paddr[2] == REG_AZ_LIMIT) az_limit_r <= pwdata[AZ_LIMIT_W-1:0];
      else depth_limit_r <= pwdata[DEPTH_LIMIT_W-1:0];
    end
  end

  // The controller steps the datapath through scan, multiply, root and divide.
  slcf_ctrl #(.SPAN(SPAN)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  slcf_datapath #(.SPAN(SPAN), .COORD_BITS(COORD_BITS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_line_end    (in_line_end),
    .az_limit       (az_limit_r),
    .depth_limit    (depth_limit_r),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_z          (out_z),
    .out_smoothness (out_smoothness)
  );

endmodule

// ----- src/slcf_checker.sv -----
// Port-level checks of the scan-line curvature filter and their binding.
`timescale 1ns / 1ps
module slcf_checker #(
  parameter int COORD_BITS = slcf_pkg::COORD_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [COORD_BITS-1:0]  out_x,
  input logic signed [COORD_BITS-1:0]  out_y,
  input logic signed [COORD_BITS-1:0]  out_z,
  input logic [slcf_pkg::SMOOTH_W-1:0] out_smoothness
);

  // A stalled result keeps its valid and payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_smoothness) && $stable(out_x) &&
    $stable(out_y) && $stable(out_z))
    else $error("result changed while stalled");

  // A new result only appears at the end of an evaluation that held the input.
  a_out_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an evaluation");

  // After reset no result is pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // An input transfer that starts an evaluation raises no new result as it starts.
  a_eval_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 !in_ready |-> !out_valid || $past(out_valid))
    else $error("result raised during evaluation start");

endmodule

bind scan_line_curvature_filter_core slcf_checker #(.COORD_BITS(COORD_BITS)) u_slcf_checker (.*);
